>>> sv/maft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// maft_pkg
// Shared types, codes and helpers for the masked address filter table.
// ============================================================================
package maft_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int USED_W              = 11;
    localparam int ADDR_W              = 32;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    localparam logic [ADDR_W-1:0] FREE_MARK = 32'hffff_ffff;
    localparam logic [7:0]        OCTET_ALL = 8'd255;

    // register index decode: bit 2 of the byte address
    localparam logic REG_BAN_MODE = 1'b0;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CHECK  = 2'd0;
    localparam kind_t KIND_ADD    = 2'd1;
    localparam kind_t KIND_REMOVE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_DONE    = 2'd0;
    localparam status_t STATUS_FULL    = 2'd1;
    localparam status_t STATUS_MISSING = 2'd2;

    typedef enum logic [1:0] {
        WR_AT_IDX   = 2'd0,
        WR_AT_COUNT = 2'd1,
        WR_AT_PREV  = 2'd2
    } wr_mode_t;

    typedef struct packed {
        logic     accept;
        logic     idx_inc;
        logic     wr_en;
        wr_mode_t wr_mode;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_load;
        logic     res_check;
        logic     res_hit;
        status_t  res_status;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic full;
        logic hit_check;
        logic hit_free;
        logic hit_exact;
    } stat_t;

    // nonzero octet -> 255 in the mask, zero octet -> wildcard
    function automatic logic [ADDR_W-1:0] octet_mask(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int k = 0; k < 4; k++) begin
            if (addr[8*k +: 8] != 8'd0) begin
                m[8*k +: 8] = OCTET_ALL;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> sv/maft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// maft_ctrl
// Sequencer for scan, append, reuse, remove-and-shift and result delivery.
// ============================================================================
module maft_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire maft_pkg::kind_t s_kind,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire maft_pkg::stat_t stat,
    output maft_pkg::cmd_t      cmd
);
    import maft_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_ADD    = 6'b000100,
        ST_REMOVE = 6'b001000,
        ST_SHIFT  = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_mode    = WR_AT_IDX;
        cmd.res_status = STATUS_DONE;
        s_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (s_kind)
                        KIND_CHECK:  state_next = ST_CHECK;
                        KIND_ADD:    state_next = ST_ADD;
                        KIND_REMOVE: state_next = ST_REMOVE;
                        default: begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_RESP;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (stat.at_end) begin
                    cmd.res_load  = 1'b1;
                    cmd.res_check = 1'b1;
                    state_next    = ST_RESP;
                end else if (stat.hit_check) begin
                    cmd.res_load  = 1'b1;
                    cmd.res_check = 1'b1;
                    cmd.res_hit   = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_ADD: begin
                if (stat.at_end) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                    if (stat.full) begin
                        cmd.res_status = STATUS_FULL;
                    end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_mode = WR_AT_COUNT;
                        cmd.cnt_inc = 1'b1;
                    end
                end else if (stat.hit_free) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_mode  = WR_AT_IDX;
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_REMOVE: begin
                if (stat.at_end) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STATUS_MISSING;
                    state_next     = ST_RESP;
                end else begin
                    cmd.idx_inc = 1'b1;
                    if (stat.hit_exact) begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (stat.at_end) begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_mode = WR_AT_PREV;
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

>>> sv/maft_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// maft_datapath
// Filter memory, scan pointer, entry count and result registers.
// ============================================================================
module maft_datapath #(
    parameter int TABLE_DEPTH = maft_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire maft_pkg::cmd_t                cmd,
    output maft_pkg::stat_t                    stat,
    input  wire logic [maft_pkg::ADDR_W-1:0]   in_address,
    input  wire logic                          ban_mode,
    output logic                               out_reject,
    output maft_pkg::status_t                  out_status,
    output logic [maft_pkg::USED_W-1:0]        out_used_entries
);
    import maft_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // only the compare value is stored: the mask is always octet_mask(compare)
    logic [ADDR_W-1:0] table_mem [TABLE_DEPTH];

    logic [ADDR_W-1:0] item_addr_reg;
    logic [ADDR_W-1:0] rd_data_reg;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_prev;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [ADDR_W-1:0] wr_data;
    logic              res_reject_reg;
    status_t           res_status_reg;
    logic              out_reject_reg;
    status_t           out_status_reg;
    logic [USED_W-1:0] out_used_reg;
    logic [CW+USED_W-1:0] used_ext;

    // read one ahead: rd_data_reg always holds the entry at idx_reg
    always_comb begin
        if (cmd.accept) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CW'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    assign rd_addr  = idx_next[AW-1:0];
    assign idx_prev = idx_reg - CW'(1);

    always_comb begin
        case (cmd.wr_mode)
            WR_AT_COUNT: wr_addr = count_reg[AW-1:0];
            WR_AT_PREV:  wr_addr = idx_prev[AW-1:0];
            default:     wr_addr = idx_reg[AW-1:0];
        endcase
    end

    assign wr_data = (cmd.wr_mode == WR_AT_PREV) ? rd_data_reg : item_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        stat.at_end    = (idx_reg == count_reg);
        stat.full      = (count_reg == CW'(TABLE_DEPTH));
        stat.hit_check = ((item_addr_reg & octet_mask(rd_data_reg)) == rd_data_reg);
        stat.hit_free  = (rd_data_reg == FREE_MARK);
        stat.hit_exact = (rd_data_reg == item_addr_reg);
    end

    assign used_ext = {{USED_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_addr_reg <= in_address;
        end
        if (cmd.res_load) begin
            res_reject_reg <= cmd.res_check & (cmd.res_hit ? ban_mode : ~ban_mode);
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load) begin
            out_reject_reg <= res_reject_reg;
            out_status_reg <= res_status_reg;
            out_used_reg   <= used_ext[USED_W-1:0];
        end
    end

    assign out_reject       = out_reject_reg;
    assign out_status       = out_status_reg;
    assign out_used_entries = out_used_reg;

endmodule
`default_nettype wire

>>> sv/masked_address_filter_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// masked_address_filter_table
// Ordered IPv4 filter table with check, add and remove words.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready, s_kind, s_address) takes one word per
//   operation: check an address, add a filter, or remove a filter. Every
//   accepted word returns exactly one result word on the output channel
//   (m_valid/m_ready, m_reject, m_status, m_used_entries).
//   The filter table lives in one memory with a registered read port, walked
//   one entry per clock. A check or add stops at the entry that hits, or
//   when the walk runs off the used entries; a remove always walks all of
//   them, since the scan continues as a shift of the later entries down by
//   one. An unused kind goes straight to its result. The sequencer idles
//   again as the result is loaded, so the next word can be taken in the
//   following cycle. A finished result sits in an output register, so the
//   next word may be accepted while the receiver stalls; that word's result
//   then waits until the output register is taken.
//   Reset clears the entry count, the handshakes and sets ban_mode to 1.
//   ban_mode sits at byte address 0 of the APB port; write it only while idle.
// ============================================================================
module masked_address_filter_table #(
    parameter int TABLE_DEPTH = maft_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [maft_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [maft_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [maft_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    // input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_kind,
    input  wire logic [maft_pkg::ADDR_W-1:0]       s_address,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_reject,
    output logic [1:0]                             m_status,
    output logic [maft_pkg::USED_W-1:0]            m_used_entries
);
    import maft_pkg::*;

    logic    ban_mode_reg, ban_mode_next;
    logic    cfg_write;
    logic    reg_sel;
    cmd_t    cmd;
    stat_t   stat;
    status_t status_w;

    // configuration register: no wait states
    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel & penable & pwrite;

    always_comb begin
        ban_mode_next = ban_mode_reg;
        if (cfg_write && reg_sel == REG_BAN_MODE) begin
            ban_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ban_mode_reg <= 1'b1;
        end else begin
            ban_mode_reg <= ban_mode_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == REG_BAN_MODE) begin
            prdata = {{(APB_DATA_W-1){1'b0}}, ban_mode_reg};
        end
    end

    // sequencer: decides the walk, writes and result timing
    maft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table memory, pointers and result registers
    maft_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_address       (s_address),
        .ban_mode         (ban_mode_reg),
        .out_reject       (m_reject),
        .out_status       (status_w),
        .out_used_entries (m_used_entries)
    );

    assign m_status = status_w;

endmodule
`default_nettype wire

>>> dv/maft_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// maft_tb_pkg
// Filter table predictor and result scoreboard for the testbench.
// ============================================================================
package maft_tb_pkg;

    import maft_pkg::*;

    localparam kind_t                 KIND_UNUSED   = 2'd3;
    localparam logic [APB_ADDR_W-1:0] BAN_MODE_ADDR = '0;
    localparam int                    TABLE_SLOTS   = DEFAULT_TABLE_DEPTH;

    typedef struct packed {
        logic              reject;
        status_t           status;
        logic [USED_W-1:0] used_entries;
    } filter_result_t;

    class filter_table_scoreboard;

        bit [ADDR_W-1:0] mask_mem [TABLE_SLOTS];
        bit [ADDR_W-1:0] cmp_mem  [TABLE_SLOTS];
        int unsigned     used;
        bit              ban;
        int unsigned     errors;
        filter_result_t  expected_q [$];

        function new();
            used   = 0;
            ban    = 1'b1;
            errors = 0;
        endfunction

        function void set_ban(bit value);
            ban = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // zero octet -> wildcard byte, any other octet -> full byte compare
        static function bit [ADDR_W-1:0] wildcard_mask(bit [ADDR_W-1:0] addr);
            bit [ADDR_W-1:0] m;
            m = '0;
            for (int k = 0; k < 4; k++) begin
                if (addr[8*k +: 8] != 8'd0) begin
                    m[8*k +: 8] = 8'hff;
                end
            end
            return m;
        endfunction

        // apply one accepted word to the table and queue the result it causes
        function void note_word(kind_t kind, bit [ADDR_W-1:0] addr);
            filter_result_t  r;
            bit [ADDR_W-1:0] m;
            int unsigned     i;
            bit              hit;
            r        = '0;
            r.status = STATUS_DONE;
            m        = wildcard_mask(addr);
            i        = 0;
            hit      = 1'b0;
            case (kind)
                KIND_CHECK: begin
                    while (i < used && !hit) begin
                        hit = ((addr & mask_mem[i]) == cmp_mem[i]);
                        i++;
                    end
                    r.reject = hit ? ban : !ban;
                end
                KIND_ADD: begin
                    while (i < used && cmp_mem[i] != FREE_MARK) begin
                        i++;
                    end
                    if (i == used && used >= TABLE_SLOTS) begin
                        r.status = STATUS_FULL;
                    end else begin
                        if (i == used) begin
                            used++;
                        end
                        mask_mem[i] = m;
                        cmp_mem[i]  = addr;
                    end
                end
                KIND_REMOVE: begin
                    while (i < used && !(mask_mem[i] == m && cmp_mem[i] == addr)) begin
                        i++;
                    end
                    if (i == used) begin
                        r.status = STATUS_MISSING;
                    end else begin
                        while (i + 1 < used) begin
                            mask_mem[i] = mask_mem[i+1];
                            cmp_mem[i]  = cmp_mem[i+1];
                            i++;
                        end
                        used--;
                    end
                end
                default: begin
                end
            endcase
            r.used_entries = used[USED_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic reject, logic [1:0] status,
                                   logic [USED_W-1:0] used_entries);
            filter_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $error("result word with no expectation pending");
                return;
            end
            want = expected_q.pop_front();
            if (reject !== want.reject) begin
                errors++;
                $error("m_reject: expected %0d, got %0d", want.reject, reject);
            end
            if (status !== want.status) begin
                errors++;
                $error("m_status: expected %0d, got %0d", want.status, status);
            end
            if (used_entries !== want.used_entries) begin
                errors++;
                $error("m_used_entries: expected %0d, got %0d",
                       want.used_entries, used_entries);
            end
        endfunction

    endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the masked address filter table: directed words,
// then random traffic under three idle mixes.
// ============================================================================
module tb_top;

    import maft_pkg::*;
    import maft_tb_pkg::*;

    // a remove on a full table is one of the longest words
    localparam int STALL_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 1100;
    localparam int RANDOM_PER_PHASE = 88;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_kind    = '0;
    logic [ADDR_W-1:0]     s_address = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_reject;
    logic [1:0]            m_status;
    logic [USED_W-1:0]     m_used_entries;

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned idle_cycles   = 0;

    filter_table_scoreboard sb = new();

    masked_address_filter_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reject       (m_reject),
        .m_status       (m_status),
        .m_used_entries (m_used_entries)
    );

    always #1 aclk = ~aclk;

    // Receiver: stall at random per cycle, drive on the falling edge only.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Check every result word taken at a rising edge against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_reject, m_status, m_used_entries);
        end
    end

    // Watchdog: count cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one input word; called and returns at a falling edge.
    // Idle gaps drop valid and scramble the payload; once valid is up, hold it.
    task automatic send_word(input kind_t kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid   <= 1'b0;
            s_kind    <= kind_t'($urandom_range(3));
            s_address <= $urandom();
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_address <= addr;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_word(kind, addr);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted result word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // APB write of ban_mode: setup cycle, then access until pready; upper bits are noise.
    task automatic write_ban_mode(input bit value);
        logic [APB_DATA_W-1:0] word;
        word    = $urandom();
        word[0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BAN_MODE_ADDR;
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        sb.set_ban(value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Filter octets: mostly a mix of wildcards and values, sometimes all ones
    // (the free mark) or a fully random word.
    function automatic logic [ADDR_W-1:0] random_filter();
        logic [ADDR_W-1:0] a;
        a = $urandom();
        if ($urandom_range(19) == 0) begin
            return FREE_MARK;
        end
        if ($urandom_range(9) == 0) begin
            return a;
        end
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(9) < 4) begin
                a[8*k +: 8] = 8'd0;
            end
        end
        return a;
    endfunction

    // Address aimed at a stored filter: fill its wildcard octets, and now and
    // then flip one bit for a near miss.
    function automatic logic [ADDR_W-1:0] probe_address(input logic [ADDR_W-1:0] filt);
        logic [ADDR_W-1:0] a;
        a = filt;
        for (int k = 0; k < 4; k++) begin
            if (a[8*k +: 8] == 8'd0) begin
                a[8*k +: 8] = 8'($urandom_range(255));
            end
        end
        if ($urandom_range(4) == 0) begin
            a[$urandom_range(ADDR_W-1)] ^= 1'b1;
        end
        return a;
    endfunction

    // One random word; keep the table short so scans stay cheap, and steer most
    // removes and half of the checks at stored filters so that they tend to hit.
    task automatic send_random_word(output bit counted);
        int unsigned       pick;
        int unsigned       add_share;
        logic [ADDR_W-1:0] a;
        pick      = $urandom_range(99);
        add_share = (sb.used > 24) ? 15 : 35;
        counted   = 1'b1;
        if (pick < 3) begin
            counted = 1'b0;
            send_word(KIND_UNUSED, $urandom());
        end else if (pick < 43) begin
            if (sb.used > 0 && $urandom_range(1) == 1) begin
                a = probe_address(sb.cmp_mem[$urandom_range(sb.used - 1)]);
            end else begin
                a = $urandom();
            end
            send_word(KIND_CHECK, a);
        end else if (pick < 43 + add_share) begin
            send_word(KIND_ADD, random_filter());
        end else begin
            if (sb.used > 0 && $urandom_range(9) < 7) begin
                a = sb.cmp_mem[$urandom_range(sb.used - 1)];
            end else begin
                a = random_filter();
            end
            send_word(KIND_REMOVE, a);
        end
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned done;
        bit          counted;
        done = 0;
        while (done < count) begin
            send_random_word(counted);
            if (counted) begin
                done++;
            end
        end
    endtask

    initial begin
        // hold reset, then release it on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words, ban mode at its reset value first.
        send_word(KIND_CHECK,  32'h0a00_0001);   // empty table, nothing matches
        send_word(KIND_REMOVE, 32'h0102_0304);   // remove on empty table
        send_word(KIND_ADD,    32'h0a00_0000);   // wildcard octets
        send_word(KIND_CHECK,  32'h0a14_1e28);
        send_word(KIND_CHECK,  32'h0b00_0000);
        send_word(KIND_ADD,    FREE_MARK);       // stores a reusable slot
        send_word(KIND_ADD,    32'hc0a8_0000);   // takes that slot over
        send_word(KIND_ADD,    FREE_MARK);
        send_word(KIND_ADD,    32'h0000_0000);   // all-wildcard filter matches all
        send_word(KIND_CHECK,  32'h0000_0000);
        send_word(KIND_ADD,    32'h0102_0304);
        send_word(KIND_CHECK,  32'h0102_0304);
        send_word(KIND_REMOVE, 32'h0a00_0000);   // first entry, shift the rest down
        send_word(KIND_REMOVE, 32'h0a00_0000);   // gone now
        send_word(KIND_REMOVE, 32'h0000_0000);
        send_word(KIND_CHECK,  FREE_MARK);
        send_word(KIND_ADD,    FREE_MARK);
        send_word(KIND_REMOVE, FREE_MARK);
        send_word(KIND_UNUSED, FREE_MARK);       // unused kind leaves state alone
        send_word(KIND_UNUSED, 32'h0000_0000);
        drain_results();

        // Allow-list mode: only matching addresses pass.
        write_ban_mode(1'b0);
        send_word(KIND_CHECK,  32'hc0a8_0101);
        send_word(KIND_CHECK,  32'h0102_0305);
        send_word(KIND_CHECK,  32'h8000_0000);
        send_word(KIND_REMOVE, 32'hc0a8_0000);
        send_word(KIND_CHECK,  32'hc0a8_0101);
        drain_results();

        // Random traffic: sender idles lightly, receiver heavily.
        write_ban_mode(1'b1);
        src_idle_pct  = 17;
        sink_idle_pct = 45;
        random_phase(RANDOM_PER_PHASE);
        drain_results();

        // Swap the idle mix.
        write_ban_mode(1'b0);
        src_idle_pct  = 45;
        sink_idle_pct = 17;
        random_phase(RANDOM_PER_PHASE);
        drain_results();

        // Full rate on both sides.
        write_ban_mode(1'b1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(RANDOM_PER_PHASE - 1);
        drain_results();

        // let any stray result word surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
